// ===== sv/feathered_mosaic_blend_macros.svh =====
// Assertion helpers shared by the RTL
`ifndef FEATHERED_MOSAIC_BLEND_MACROS_SVH
`define FEATHERED_MOSAIC_BLEND_MACROS_SVH

// same-cycle implication
`define FMB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("feathered_mosaic_blend: same-cycle check failed");

// next-cycle implication
`define FMB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("feathered_mosaic_blend: next-cycle check failed");

`endif

// ===== sv/fmb_pkg.sv =====
`timescale 1ns / 1ps

package fmb_pkg;

    localparam int COORD_W   = 25;
    localparam int PIX_W     = 16;
    localparam int SAMPLE_W  = 16;
    localparam int OVL_W     = 8;
    localparam int WEIGHT_W  = 17;            // Q1.16, 1.0 needs the 17th bit
    localparam int ACC_W     = 40;
    localparam int WSUM_W    = 24;
    localparam int FRAC_BITS = 8;

    localparam logic [FRAC_BITS-1:0] HALF_PIXEL = 8'h80;
    localparam logic [WEIGHT_W-1:0]  WEIGHT_ONE = 17'h10000;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

    localparam int WDIV_STEPS = WEIGHT_W;     // weight quotient bits
    localparam int PDIV_STEPS = ACC_W;        // pixel quotient bits

    typedef enum logic [1:0] {
        CFG_OVERLAP_X    = 2'd0,
        CFG_OVERLAP_Y    = 2'd1,
        CFG_NODATA_EN    = 2'd2,
        CFG_NODATA_VALUE = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [OVL_W-1:0]           overlap_x;
        logic [OVL_W-1:0]           overlap_y;
        logic                       nodata_enable;
        logic signed [SAMPLE_W-1:0] nodata_value;
    } t_cfg;

    typedef struct packed {
        logic [WEIGHT_W-1:0]        weight;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_qentry;

endpackage

// ===== sv/fmb_queue.sv =====
`timescale 1ns / 1ps

module fmb_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fmb_pkg::t_qentry i_data,
    output logic             o_full,
    input  logic             i_pop,
    output fmb_pkg::t_qentry o_data,
    output logic             o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    fmb_pkg::t_qentry r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== sv/fmb_front.sv =====
`timescale 1ns / 1ps

module fmb_front (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  fmb_pkg::t_cfg                            i_cfg,
    input  logic                                     i_push,
    output logic                                     o_full,
    input  logic [fmb_pkg::PIX_W-1:0]                i_pixel_x,
    input  logic [fmb_pkg::PIX_W-1:0]                i_pixel_y,
    input  logic signed [fmb_pkg::COORD_W-1:0]       i_valid_left,
    input  logic signed [fmb_pkg::COORD_W-1:0]       i_valid_top,
    input  logic signed [fmb_pkg::COORD_W-1:0]       i_valid_right,
    input  logic signed [fmb_pkg::COORD_W-1:0]       i_valid_bottom,
    input  logic signed [fmb_pkg::SAMPLE_W-1:0]      i_sample,
    input  logic                                     i_mask_valid,
    input  logic                                     i_last_source,
    output logic                                     o_q_push,
    output fmb_pkg::t_qentry                         o_q_data,
    input  logic                                     i_q_full
);

    typedef enum logic [5:0] {
        F_IDLE = 6'b000001,
        F_CALC = 6'b000010,
        F_MUL  = 6'b000100,
        F_ADDH = 6'b001000,
        F_DIV  = 6'b010000,
        F_PUSH = 6'b100000
    } t_fstate;

    t_fstate r_state, n_state;

    logic [fmb_pkg::PIX_W-1:0]           r_px, r_py;
    logic signed [fmb_pkg::COORD_W-1:0]  r_vl, r_vt, r_vr, r_vb;
    logic signed [fmb_pkg::SAMPLE_W-1:0] r_sample;
    logic                                r_mask, r_last;
    logic [16:0]                         r_w, r_h;
    logic [33:0]                         r_num;
    logic [17:0]                         r_den;
    logic [17:0]                         r_rem;
    logic [fmb_pkg::WEIGHT_W-1:0]        r_dvd;   // dividend bits, then quotient
    logic [4:0]                          r_cnt;

    // centre and window edges, 27 bits signed
    logic signed [26:0] cx, cy, vl, vt, vr, vb, ox, oy;
    logic signed [26:0] hi_x, lo_x, hi_y, lo_y;
    logic signed [27:0] span_w, span_h;
    logic               in_rect, hard_cut, area_pos;
    logic [34:0]        num_rnd;
    logic [18:0]        trial;
    logic               ge;

    always_comb begin
        cx = {3'b000, r_px, fmb_pkg::HALF_PIXEL};
        cy = {3'b000, r_py, fmb_pkg::HALF_PIXEL};
        vl = {{2{r_vl[24]}}, r_vl};
        vt = {{2{r_vt[24]}}, r_vt};
        vr = {{2{r_vr[24]}}, r_vr};
        vb = {{2{r_vb[24]}}, r_vb};
        ox = {11'b0, i_cfg.overlap_x, 8'b0};
        oy = {11'b0, i_cfg.overlap_y, 8'b0};
        in_rect  = (cx >= vl) && (cx < vr) && (cy >= vt) && (cy < vb);
        hard_cut = (i_cfg.overlap_x == '0) || (i_cfg.overlap_y == '0);
        hi_x = (vr < cx + ox) ? vr : cx + ox;
        lo_x = (vl > cx - ox) ? vl : cx - ox;
        hi_y = (vb < cy + oy) ? vb : cy + oy;
        lo_y = (vt > cy - oy) ? vt : cy - oy;
        span_w   = {hi_x[26], hi_x} - {lo_x[26], lo_x};
        span_h   = {hi_y[26], hi_y} - {lo_y[26], lo_y};
        area_pos = (span_w > 0) && (span_h > 0);
        // numerator plus half the box area, for round-to-nearest
        num_rnd = {1'b0, r_num} + {18'b0, r_den[17:1]};
        trial   = {r_rem, r_dvd[fmb_pkg::WEIGHT_W-1]};
        ge      = (trial >= {1'b0, r_den});
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (i_push) n_state = F_CALC;
            F_CALC: begin
                if (!r_mask || hard_cut || !area_pos) n_state = F_PUSH;
                else n_state = F_MUL;
            end
            F_MUL:  n_state = F_ADDH;
            F_ADDH: n_state = F_DIV;
            F_DIV:  if (r_cnt == 5'd1) n_state = F_PUSH;
            F_PUSH: if (!i_q_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            F_IDLE: begin
                r_px     <= i_pixel_x;
                r_py     <= i_pixel_y;
                r_vl     <= i_valid_left;
                r_vt     <= i_valid_top;
                r_vr     <= i_valid_right;
                r_vb     <= i_valid_bottom;
                r_sample <= i_sample;
                r_mask   <= i_mask_valid;
                r_last   <= i_last_source;
            end
            F_CALC: begin
                r_w <= span_w[16:0];
                r_h <= span_h[16:0];
                if (!r_mask || (!hard_cut && !area_pos)) begin
                    r_dvd <= '0;
                end else if (hard_cut) begin
                    r_dvd <= in_rect ? fmb_pkg::WEIGHT_ONE : '0;
                end
            end
            F_MUL: begin
                r_num <= r_w * r_h;
                r_den <= {16'(i_cfg.overlap_x) * 16'(i_cfg.overlap_y), 2'b00};
            end
            F_ADDH: begin
                // quotient is at most 1.0, so the high part is below the divisor
                r_rem <= num_rnd[34:17];
                r_dvd <= num_rnd[16:0];
                r_cnt <= 5'(fmb_pkg::WDIV_STEPS);
            end
            F_DIV: begin
                r_rem <= ge ? 18'(trial - {1'b0, r_den}) : trial[17:0];
                r_dvd <= {r_dvd[fmb_pkg::WEIGHT_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
            end
            F_PUSH: ;
            default: ;
        endcase
    end

    assign o_full          = (r_state != F_IDLE);
    assign o_q_push        = (r_state == F_PUSH) && !i_q_full;
    assign o_q_data.weight = r_dvd;
    assign o_q_data.sample = r_sample;
    assign o_q_data.last   = r_last;

endmodule

// ===== sv/fmb_back.sv =====
`timescale 1ns / 1ps

module fmb_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fmb_pkg::t_cfg                       i_cfg,
    input  fmb_pkg::t_qentry                    i_q_data,
    input  logic                                i_q_empty,
    output logic                                o_q_pop,
    output logic                                o_empty,
    input  logic                                i_pop,
    output logic signed [fmb_pkg::SAMPLE_W-1:0] o_pixel_value,
    output logic                                o_pixel_valid
);

    localparam int AW = fmb_pkg::ACC_W;
    localparam int WW = fmb_pkg::WSUM_W;

    typedef enum logic [6:0] {
        B_IDLE = 7'b0000001,
        B_MUL  = 7'b0000010,
        B_ADD  = 7'b0000100,
        B_FIN  = 7'b0001000,
        B_DIV  = 7'b0010000,
        B_RND  = 7'b0100000,
        B_OUT  = 7'b1000000
    } t_bstate;

    t_bstate r_state, n_state;

    logic [fmb_pkg::WEIGHT_W-1:0]        r_w;
    logic signed [fmb_pkg::SAMPLE_W-1:0] r_s;
    logic                                r_last;
    logic signed [33:0]                  r_prod;
    logic signed [AW-1:0]                r_acc;
    logic [WW-1:0]                       r_wsum;
    logic [WW-1:0]                       r_den;
    logic [WW-1:0]                       r_rem;
    logic [AW-1:0]                       r_dvd;   // magnitude, then quotient
    logic                                r_neg, r_zero;
    logic [5:0]                          r_cnt;
    logic                                r_out_full, r_out_valid;
    logic signed [fmb_pkg::SAMPLE_W-1:0] r_out_value;

    logic signed [AW:0]   acc_sum;
    logic [WW:0]          wsum_sum;
    logic [WW:0]          trial, twice_rem;
    logic                 ge, round_up;
    logic signed [fmb_pkg::SAMPLE_W-1:0] res_value;
    logic                 load_out;

    always_comb begin
        acc_sum   = {r_acc[AW-1], r_acc} + (AW+1)'(r_prod);
        wsum_sum  = {1'b0, r_wsum} + (WW+1)'(r_w);
        trial     = {r_rem, r_dvd[AW-1]};
        ge        = (trial >= {1'b0, r_den});
        twice_rem = {r_rem, 1'b0};
        // round half to even
        round_up  = (twice_rem > {1'b0, r_den}) || ((twice_rem == {1'b0, r_den}) && r_dvd[0]);
        if (r_zero) begin
            res_value = i_cfg.nodata_enable ? i_cfg.nodata_value : '0;
        end else if (r_neg) begin
            res_value = (r_dvd > AW'(32768)) ? fmb_pkg::SAMPLE_MIN
                                              : -$signed(r_dvd[fmb_pkg::SAMPLE_W-1:0]);
        end else begin
            res_value = (r_dvd > AW'(32767)) ? fmb_pkg::SAMPLE_MAX
                                              : $signed(r_dvd[fmb_pkg::SAMPLE_W-1:0]);
        end
    end

    assign load_out = (r_state == B_OUT) && !r_out_full;
    assign o_q_pop  = (r_state == B_IDLE) && !i_q_empty;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: if (!i_q_empty) n_state = B_MUL;
            B_MUL:  n_state = B_ADD;
            B_ADD:  n_state = r_last ? B_FIN : B_IDLE;
            B_FIN:  n_state = (r_wsum == '0) ? B_OUT : B_DIV;
            B_DIV:  if (r_cnt == 6'd1) n_state = B_RND;
            B_RND:  n_state = B_OUT;
            B_OUT:  if (!r_out_full) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_IDLE;
            r_acc      <= '0;
            r_wsum     <= '0;
            r_out_full <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_ADD) begin
                // saturate on signed overflow
                if (acc_sum[AW] != acc_sum[AW-1]) begin
                    r_acc <= acc_sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
                end else begin
                    r_acc <= acc_sum[AW-1:0];
                end
                r_wsum <= wsum_sum[WW] ? {WW{1'b1}} : wsum_sum[WW-1:0];
            end else if (r_state == B_FIN) begin
                r_acc  <= '0;
                r_wsum <= '0;
            end
            if (load_out) begin
                r_out_full <= 1'b1;
            end else if (i_pop) begin
                r_out_full <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                r_w    <= i_q_data.weight;
                r_s    <= i_q_data.sample;
                r_last <= i_q_data.last;
            end
            B_MUL: r_prod <= r_s * $signed({1'b0, r_w});
            B_ADD: ;
            B_FIN: begin
                r_zero <= (r_wsum == '0);
                r_neg  <= r_acc[AW-1];
                r_dvd  <= r_acc[AW-1] ? AW'(-r_acc) : AW'(r_acc);
                r_den  <= r_wsum;
                r_rem  <= '0;
                r_cnt  <= 6'(fmb_pkg::PDIV_STEPS);
            end
            B_DIV: begin
                r_rem <= ge ? WW'(trial - {1'b0, r_den}) : trial[WW-1:0];
                r_dvd <= {r_dvd[AW-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
            end
            B_RND: r_dvd <= r_dvd + AW'(round_up);
            B_OUT: begin
                if (!r_out_full) begin
                    r_out_value <= res_value;
                    r_out_valid <= !r_zero;
                end
            end
            default: ;
        endcase
    end

    assign o_empty       = !r_out_full;
    assign o_pixel_value = r_out_value;
    assign o_pixel_valid = r_out_valid;

endmodule

// ===== sv/feathered_mosaic_blend.sv =====
`timescale 1ns / 1ps
`include "feathered_mosaic_blend_macros.svh"

// Feathered mosaic blend. Push one item per source sample of an output pixel
// (position, source valid rectangle in 1/256 pixel, sample, mask, last flag);
// the item with last set yields one result: the weight-averaged value, rounded
// half to even and saturated, with pixel_valid low and nodata (or 0) when no
// source gave weight. An uncovered pixel still needs one item with its mask low.
// The front weight unit captures an item, weighs it and pushes it; in feathered
// mode (both overlaps nonzero) with the mask set and a positive clipped area it
// also multiplies, adds half the box area and runs a 17-step restoring divider
// that produces the Q1.16 weight, while hard-cut mode (either overlap zero) does
// not; full is high meanwhile, and stays high while the queue is full.
// The back accumulator multiplies and adds each item, and on the last item of
// a pixel goes on to a 40-step restoring divider, rounding and output load (only
// the output load when the weight sum is zero), while the front keeps weighing
// the next pixel's items into a FIFO_DEPTH-entry queue. One finished result is
// held until popped; the back stalls only if a second result is ready before
// the first is taken.
// Configuration writes are always ready and must only happen while idle.

module feathered_mosaic_blend #(
    parameter int FIFO_DEPTH = 4          // 2 and up
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [1:0]                          i_cfg_index,
    input  logic [15:0]                         i_cfg_data,
    // source items
    input  logic                                push,
    output logic                                full,
    input  logic [fmb_pkg::PIX_W-1:0]           i_pixel_x,
    input  logic [fmb_pkg::PIX_W-1:0]           i_pixel_y,
    input  logic signed [fmb_pkg::COORD_W-1:0]  i_valid_left,
    input  logic signed [fmb_pkg::COORD_W-1:0]  i_valid_top,
    input  logic signed [fmb_pkg::COORD_W-1:0]  i_valid_right,
    input  logic signed [fmb_pkg::COORD_W-1:0]  i_valid_bottom,
    input  logic signed [fmb_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_mask_valid,
    input  logic                                i_last_source,
    // results
    output logic                                empty,
    input  logic                                pop,
    output logic signed [fmb_pkg::SAMPLE_W-1:0] o_pixel_value,
    output logic                                o_pixel_valid
);

    fmb_pkg::t_cfg    r_cfg;
    fmb_pkg::t_qentry q_wdata, q_rdata;
    logic             q_push, q_full, q_pop, q_empty;

    // Register file: every transfer is taken at once.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (fmb_pkg::t_cfg_idx'(i_cfg_index))
                fmb_pkg::CFG_OVERLAP_X:    r_cfg.overlap_x     <= i_cfg_data[7:0];
                fmb_pkg::CFG_OVERLAP_Y:    r_cfg.overlap_y     <= i_cfg_data[7:0];
                fmb_pkg::CFG_NODATA_EN:    r_cfg.nodata_enable <= i_cfg_data[0];
                fmb_pkg::CFG_NODATA_VALUE: r_cfg.nodata_value  <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Front: captures an item and works out its weight.
    fmb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_push         (push),
        .o_full         (full),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .i_valid_left   (i_valid_left),
        .i_valid_top    (i_valid_top),
        .i_valid_right  (i_valid_right),
        .i_valid_bottom (i_valid_bottom),
        .i_sample       (i_sample),
        .i_mask_valid   (i_mask_valid),
        .i_last_source  (i_last_source),
        .o_q_push       (q_push),
        .o_q_data       (q_wdata),
        .i_q_full       (q_full)
    );

    // Weighted samples waiting for the accumulator.
    fmb_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    // Back: accumulates, divides at the end of a pixel, holds the result.
    fmb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_data      (q_rdata),
        .i_q_empty     (q_empty),
        .o_q_pop       (q_pop),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_pixel_value (o_pixel_value),
        .o_pixel_valid (o_pixel_valid)
    );

    // A weight never goes into a full queue.
    `FMB_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, q_push, !q_full)
    // Clipped area never exceeds the box, so weight stays within 1.0.
    `FMB_ASSERT_IMP(a_weight_range, i_clk, i_rst_n, q_push, q_wdata.weight <= fmb_pkg::WEIGHT_ONE)
    // The front is busy in the cycle after it takes a transfer.
    `FMB_ASSERT_NXT(a_busy_after_push, i_clk, i_rst_n, push && !full, full)

endmodule
